// ===== rtl/core/linear_blend_vertex_skinning_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_UNIT_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_UNIT_ASSERT_SVH

// Clocked assertion, masked while reset is held.
`define LBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LBS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lbs_pkg.sv =====
`timescale 1ns / 1ps
package lbs_pkg;

    localparam int WORDS       = 12;  // words per bone, a1..c4
    localparam int SLOT_W      = 6;
    localparam int WT_W        = 12;
    localparam int PACKED      = 4;   // influences carried by an item
    localparam int OFIFO_DEPTH = 4;
    localparam int IN_TDATA_W  = 312;
    localparam int OUT_TDATA_W = 192;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_SKIN = 1'b1
    } t_req;

    // position and normal triple
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
    } t_pn;

    typedef struct packed {
        logic [23:0] slots;
        logic [47:0] wts;
        t_pn         g;
    } t_vtx;

    typedef struct packed {
        logic [WORDS-1:0][31:0] m;
        t_pn                    g;
    } t_blend;

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/linear_blend_vertex_skinning_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata bits  tuser      tlast
// s_axis    in   312         req_type   -
// m_axis    out  192         -          -
//
// A skin item reads the palette, one bone (all twelve words) per cycle;
// a load item writes one palette word. A result passes the palette read,
// blend stages A to D, both transform stages and the output queue. While
// a skin is in progress, loads and skins are accepted only once the
// sequencer reaches its last read. A four-entry output queue with credit
// count takes up output stalls; no stage of the datapath ever stalls.
// Reset is synchronous; the palette is not cleared and must be loaded.
module linear_blend_vertex_skinning_unit #(
    parameter int PALETTE_BONES = 64,
    parameter int INFLUENCES    = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // bone_slot, element_index, matrix_value, pos_x, pos_y, pos_z, nrm_x,
    // nrm_y, nrm_z, influence_slots, influence_weights, zero pad
    input  logic [lbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
    output logic [lbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import lbs_pkg::*;

    localparam int CW = $clog2(OFIFO_DEPTH + 1);
    localparam int PW = $clog2(OFIFO_DEPTH);

    // input unpack
    t_vtx  vtx;
    logic  s_acc, m_acc, start, wr_en, bl_ready, bl_valid, xf_valid;
    t_blend bl;
    t_pn   xf_res;

    always_comb begin
        vtx.g.px  = $signed(s_axis_tdata[73:42]);
        vtx.g.py  = $signed(s_axis_tdata[105:74]);
        vtx.g.pz  = $signed(s_axis_tdata[137:106]);
        vtx.g.nx  = $signed(s_axis_tdata[169:138]);
        vtx.g.ny  = $signed(s_axis_tdata[201:170]);
        vtx.g.nz  = $signed(s_axis_tdata[233:202]);
        vtx.slots = s_axis_tdata[257:234];
        vtx.wts   = s_axis_tdata[305:258];
    end

    // credits: skins accepted whose results are not yet taken
    logic [CW-1:0] r_cred;

    assign s_axis_tready = bl_ready && (r_cred < CW'(OFIFO_DEPTH));
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign start = s_acc && (t_req'(s_axis_tuser) == REQ_SKIN);
    assign wr_en = s_acc && (t_req'(s_axis_tuser) == REQ_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
        end else if (start && !m_acc) begin
            r_cred <= r_cred + 1'b1;
        end else if (!start && m_acc) begin
            r_cred <= r_cred - 1'b1;
        end
    end

    lbs_blend #(.PALETTE_BONES(PALETTE_BONES), .INFLUENCES(INFLUENCES)) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_slot (s_axis_tdata[5:0]),
        .i_wr_elem (s_axis_tdata[9:6]),
        .i_wr_data (s_axis_tdata[41:10]),
        .i_start   (start),
        .i_vtx     (vtx),
        .o_ready   (bl_ready),
        .o_valid   (bl_valid),
        .o_blend   (bl)
    );

    lbs_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bl_valid),
        .i_blend (bl),
        .o_valid (xf_valid),
        .o_res   (xf_res)
    );

    // output queue
    t_pn           r_q [OFIFO_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (xf_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (m_acc) begin
                r_rp <= r_rp + 1'b1;
            end
            if (xf_valid && !m_acc) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!xf_valid && m_acc) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xf_valid) begin
            r_q[r_wp] <= xf_res;
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {r_q[r_rp].nz, r_q[r_rp].ny, r_q[r_rp].nx,
                            r_q[r_rp].pz, r_q[r_rp].py, r_q[r_rp].px};
endmodule

// ===== rtl/core/lbs_ram.sv =====
`timescale 1ns / 1ps
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // one write, one registered read (old data on a same-address clash)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ===== rtl/core/lbs_blend.sv =====
`timescale 1ns / 1ps
module lbs_blend #(
    parameter int PALETTE_BONES = 64,
    parameter int INFLUENCES    = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [5:0]      i_wr_slot,
    input  logic [3:0]      i_wr_elem,
    input  logic [31:0]     i_wr_data,
    input  logic            i_start,
    input  lbs_pkg::t_vtx   i_vtx,
    output logic            o_ready,
    output logic            o_valid,
    output lbs_pkg::t_blend o_blend
);
    import lbs_pkg::*;

    localparam int AW = PALETTE_BONES > 1 ? $clog2(PALETTE_BONES) : 1;
    localparam int IW = INFLUENCES > 1 ? $clog2(INFLUENCES) : 1;
    localparam int SW = 34 + IW;
    localparam logic [IW-1:0] LAST = IW'(INFLUENCES - 1);

    // sequencer: one palette entry read per cycle
    logic          r_busy;
    logic [IW-1:0] r_cnt;
    logic [23:0]   r_slots;
    logic [47:0]   r_wts;
    t_pn           r_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_slots <= i_vtx.slots;
            r_wts   <= i_vtx.wts;
            r_geo   <= i_vtx.g;
        end
    end

    assign o_ready = !r_busy || (r_cnt == LAST);

    // influence selection for this cycle
    logic [5:0]    k_slot;
    logic [11:0]   k_wt;
    logic          k_use;
    logic [7:0]    rd_slot8;
    logic [7:0]    wr_slot8;
    logic          wr_ok;

    always_comb begin
        k_slot   = 6'(r_slots >> (SLOT_W * int'(r_cnt)));
        k_wt     = 12'(r_wts >> (WT_W * int'(r_cnt)));
        k_use    = r_busy && (int'(r_cnt) < PACKED) && (int'(k_slot) < PALETTE_BONES);
        rd_slot8 = {2'b00, k_slot};
        wr_slot8 = {2'b00, i_wr_slot};
        wr_ok    = i_wr_en && (int'(i_wr_slot) < PALETTE_BONES) && (int'(i_wr_elem) < WORDS);
    end

    // palette: one memory per matrix word, all read at the same bone
    logic [31:0] ram_q [WORDS];

    for (genvar e = 0; e < WORDS; e++) begin : g_pal
        lbs_ram #(.WIDTH(32), .DEPTH(PALETTE_BONES)) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_ok && (i_wr_elem == 4'(e))),
            .i_waddr (wr_slot8[AW-1:0]),
            .i_wdata (i_wr_data),
            .i_re    (k_use),
            .i_raddr (rd_slot8[AW-1:0]),
            .o_rdata (ram_q[e])
        );
    end

    // stage A: aligned with the memory output
    logic        r_a_valid, r_a_use, r_a_first, r_a_last;
    logic [11:0] r_a_wt;
    t_pn         r_a_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= r_busy;
        end
        r_a_use   <= k_use;
        r_a_first <= (r_cnt == '0);
        r_a_last  <= (r_cnt == LAST);
        r_a_wt    <= k_wt;
        r_a_geo   <= r_geo;
    end

    // stage B: weight the words
    logic               r_b_valid, r_b_first, r_b_last;
    t_pn                r_b_geo;
    logic signed [32:0] r_b_prod [WORDS];
    logic signed [44:0] n_prod   [WORDS];

    always_comb begin
        for (int e = 0; e < WORDS; e++) begin
            n_prod[e] = $signed(ram_q[e]) * $signed({1'b0, r_a_wt});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_first <= r_a_first;
        r_b_last  <= r_a_last;
        r_b_geo   <= r_a_geo;
        for (int e = 0; e < WORDS; e++) begin
            r_b_prod[e] <= r_a_use ? n_prod[e][43:11] : 33'sd0;
        end
    end

    // stage C: accumulate over influences
    logic               r_c_valid;
    t_pn                r_c_geo;
    logic signed [SW-1:0] r_sum [WORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid && r_b_last;
        end
        if (r_b_valid) begin
            for (int e = 0; e < WORDS; e++) begin
                r_sum[e] <= r_b_first ? SW'(r_b_prod[e]) : r_sum[e] + SW'(r_b_prod[e]);
            end
        end
        r_c_geo <= r_b_geo;
    end

    // stage D: saturate the blended matrix
    logic   r_d_valid;
    t_blend r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        for (int e = 0; e < WORDS; e++) begin
            r_d.m[e] <= sat32(50'(r_sum[e]));
        end
        r_d.g <= r_c_geo;
    end

    assign o_valid = r_d_valid;
    assign o_blend = r_d;
endmodule

// ===== rtl/core/lbs_xform.sv =====
`timescale 1ns / 1ps
module lbs_xform (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lbs_pkg::t_blend i_blend,
    output logic            o_valid,
    output lbs_pkg::t_pn    o_res
);
    import lbs_pkg::*;

    // stage 1: nine products for the position, nine for the normal
    logic signed [63:0] n_pp [3][3];
    logic signed [63:0] n_np [3][3];
    logic signed [47:0] r_pp [3][3];
    logic signed [47:0] r_np [3][3];
    logic signed [31:0] r_tr [3];
    logic               r_v1;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_pp[r][0] = $signed(i_blend.m[4*r])   * i_blend.g.px;
            n_pp[r][1] = $signed(i_blend.m[4*r+1]) * i_blend.g.py;
            n_pp[r][2] = $signed(i_blend.m[4*r+2]) * i_blend.g.pz;
            n_np[r][0] = $signed(i_blend.m[4*r])   * i_blend.g.nx;
            n_np[r][1] = $signed(i_blend.m[4*r+1]) * i_blend.g.ny;
            n_np[r][2] = $signed(i_blend.m[4*r+2]) * i_blend.g.nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                r_pp[r][j] <= n_pp[r][j][63:16];
                r_np[r][j] <= n_np[r][j][63:16];
            end
            r_tr[r] <= $signed(i_blend.m[4*r+3]);
        end
    end

    // stage 2: row sums, translation on the position only
    logic signed [49:0] n_ps [3];
    logic signed [49:0] n_ns [3];
    logic               r_v2;
    t_pn                r_res;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_ps[r] = 50'(r_pp[r][0]) + 50'(r_pp[r][1]) + 50'(r_pp[r][2]) + 50'(r_tr[r]);
            n_ns[r] = 50'(r_np[r][0]) + 50'(r_np[r][1]) + 50'(r_np[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_res.px <= sat32(n_ps[0]);
        r_res.py <= sat32(n_ps[1]);
        r_res.pz <= sat32(n_ps[2]);
        r_res.nx <= sat32(n_ns[0]);
        r_res.ny <= sat32(n_ns[1]);
        r_res.nz <= sat32(n_ns[2]);
    end

    assign o_valid = r_v2;
    assign o_res   = r_res;
endmodule

// ===== rtl/core/lbs_checker.sv =====
`timescale 1ns / 1ps
`include "linear_blend_vertex_skinning_unit_assert.svh"
module lbs_checker #(
    parameter int PALETTE_BONES = 64,
    parameter int INFLUENCES    = 4
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic s_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    import lbs_pkg::*;

    logic s_acc, m_hold, skin_acc, big;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign skin_acc = s_acc && (s_axis_tuser == REQ_SKIN);
    assign m_hold   = m_axis_tvalid && !m_axis_tready;
    assign big      = (INFLUENCES > 1) && (PALETTE_BONES > 0);

    // a stalled result stays offered
    `LBS_ASSERT(a_out_hold, i_clk, i_rst_n, m_hold |=> m_axis_tvalid, "result dropped")
    // reset empties the output queue
    `LBS_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid out of reset")
    // a skin item holds the palette port for its further reads
    `LBS_ASSERT(a_skin_busy, i_clk, i_rst_n, (big && skin_acc) |=> !s_axis_tready,
        "item taken during palette reads")
    // no result can appear on the cycle right after reset
    `LBS_ASSERT(a_no_early, i_clk, i_rst_n, $rose(i_rst_n) |-> !m_axis_tvalid,
        "result without item")
endmodule

bind linear_blend_vertex_skinning_unit lbs_checker #(
    .PALETTE_BONES(PALETTE_BONES),
    .INFLUENCES(INFLUENCES)
) u_lbs_checker (.*);
